/* hw/rtl/xbrv_pkg.sv */
package xbrv_pkg;

	// Configuration port geometry
	localparam int unsigned ADDR_W = 4;
	localparam int unsigned DATA_W = 32;

	// Register indexes (byte address is 4 times the index)
	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_SIZE   = 2'd2;

	// Register reset values
	localparam logic [7:0]  WIDTH_RST  = 8'd80;
	localparam logic [7:0]  HEIGHT_RST = 8'd25;
	localparam logic [15:0] SIZE_RST   = 16'd0;

	// Result status codes
	localparam logic [3:0] ST_MORE       = 4'd0;
	localparam logic [3:0] ST_LINE       = 4'd1;
	localparam logic [3:0] ST_IMAGE      = 4'd2;
	localparam logic [3:0] ST_DIMS       = 4'd3;
	localparam logic [3:0] ST_OFFSET     = 4'd4;
	localparam logic [3:0] ST_LEAVES     = 4'd5;
	localparam logic [3:0] ST_HDR_TRUNC  = 4'd6;
	localparam logic [3:0] ST_LIT_TRUNC  = 4'd7;
	localparam logic [3:0] ST_CA_TRUNC   = 4'd8;
	localparam logic [3:0] ST_CELL_TRUNC = 4'd9;
	localparam logic [3:0] ST_UNEXPECTED = 4'd10;

	// Request kinds
	localparam logic REQ_LINE_START = 1'b0;
	localparam logic REQ_DATA_BYTE  = 1'b1;

	// Run types in the top two bits of a run header
	localparam logic [1:0] KIND_LIT  = 2'b00;
	localparam logic [1:0] KIND_CHAR = 2'b01;
	localparam logic [1:0] KIND_ATTR = 2'b10;
	localparam logic [1:0] KIND_CELL = 2'b11;

	typedef struct packed {
		logic [7:0]  image_width;
		logic [7:0]  image_height;
		logic [15:0] data_len;
	} cfg_t;

	typedef struct packed {
		logic        req_type;
		logic [15:0] line_offset;
		logic [7:0]  data_byte;
	} req_t;

	typedef struct packed {
		logic [3:0] status;
		logic [7:0] line_number;
		logic [7:0] column;
	} res_t;

endpackage

/* hw/rtl/xbrv_if.sv */
interface xbrv_req_if;
	logic        valid;
	logic        ready;
	logic        req_type;
	logic [15:0] line_offset;
	logic [7:0]  data_byte;

	modport source (output valid, output req_type, output line_offset, output data_byte,
		input ready);
	modport sink (input valid, input req_type, input line_offset, input data_byte,
		output ready);
endinterface

interface xbrv_rsp_if;
	logic       valid;
	logic       ready;
	logic [3:0] status;
	logic [7:0] line_number;
	logic [7:0] column;

	modport source (output valid, output status, output line_number, output column,
		input ready);
	modport sink (input valid, input status, input line_number, input column,
		output ready);
endinterface

/* hw/rtl/xbrv_cfg.sv */
module xbrv_cfg import xbrv_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t       cfg_q;
	logic       wr_en;
	logic [1:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[3:2];
	assign cfg     = cfg_q;

	// Write a register on the access beat; addresses past the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_width  <= WIDTH_RST;
			cfg_q.image_height <= HEIGHT_RST;
			cfg_q.data_len     <= SIZE_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_WIDTH:  cfg_q.image_width  <= pwdata[7:0];
				REG_HEIGHT: cfg_q.image_height <= pwdata[7:0];
				REG_SIZE:   cfg_q.data_len     <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// Read back
	always_comb begin
		unique case (reg_idx)
			REG_WIDTH:  prdata = {24'd0, cfg_q.image_width};
			REG_HEIGHT: prdata = {24'd0, cfg_q.image_height};
			REG_SIZE:   prdata = {16'd0, cfg_q.data_len};
			default:    prdata = '0;
		endcase
	end

endmodule

/* hw/rtl/xbrv_core.sv */
module xbrv_core import xbrv_pkg::*; #(
	parameter int unsigned AREA_MAX = 32768
) (
	input  logic clk,
	input  logic arst_n,
	input  logic fire,
	input  cfg_t cfg,
	input  req_t item,
	output res_t res
);

	// Line walker state
	logic [3:0]  err_q,   err_d;
	logic [7:0]  col_q,   col_d;
	logic [15:0] bpos_q,  bpos_d;
	logic [7:0]  pleft_q, pleft_d;
	logic [6:0]  prun_q,  prun_d;
	logic [7:0]  lines_q, lines_d;
	logic        inl_q,   inl_d;

	logic [3:0]  status;
	logic [6:0]  len;
	logic [1:0]  kind;
	logic [7:0]  need;
	logic [3:0]  trunc_code;
	logic [15:0] room;
	logic [15:0] area;
	logic        dims_bad;
	logic [8:0]  col_sum;
	logic [7:0]  col_adv;
	logic [7:0]  pleft_dec;

	// Decode the header fields and the checks they feed
	always_comb begin
		len       = {1'b0, item.data_byte[5:0]} + 7'd1;
		kind      = item.data_byte[7:6];
		area      = 16'(cfg.image_width) * 16'(cfg.image_height);
		dims_bad  = (cfg.image_width == 8'd0) || (cfg.image_height == 8'd0)
			|| (32'(area) > 32'(AREA_MAX));
		room      = cfg.data_len - bpos_q - 16'd1;
		col_sum   = {1'b0, col_q} + {2'b00, len};
		col_adv   = col_q + {1'b0, prun_q};
		pleft_dec = pleft_q - 8'd1;
		case (kind)
			KIND_LIT: begin
				need       = {len, 1'b0};
				trunc_code = ST_LIT_TRUNC;
			end
			KIND_CELL: begin
				need       = 8'd2;
				trunc_code = ST_CELL_TRUNC;
			end
			default: begin
				need       = {1'b0, len} + 8'd1;
				trunc_code = ST_CA_TRUNC;
			end
		endcase
	end

	// Work out the next state and the status for the current item
	always_comb begin
		err_d   = err_q;
		col_d   = col_q;
		bpos_d  = bpos_q;
		pleft_d = pleft_q;
		prun_d  = prun_q;
		lines_d = lines_q;
		inl_d   = inl_q;
		status  = ST_MORE;
		if (err_q != ST_MORE) begin
			status = err_q;
		end else if (item.req_type == REQ_LINE_START) begin
			if (inl_q) begin
				status = ST_UNEXPECTED;
			end else if (dims_bad) begin
				status = ST_DIMS;
			end else if (lines_q >= cfg.image_height) begin
				status = ST_UNEXPECTED;
			end else if (item.line_offset >= cfg.data_len) begin
				status = ST_OFFSET;
			end else begin
				bpos_d  = item.line_offset;
				col_d   = 8'd0;
				pleft_d = 8'd0;
				prun_d  = 7'd0;
				inl_d   = 1'b1;
			end
			err_d = status;
		end else if (!inl_q) begin
			status = ST_UNEXPECTED;
			err_d  = status;
		end else if (pleft_q == 8'd0) begin
			// Run header
			if (bpos_q >= cfg.data_len) begin
				status = ST_HDR_TRUNC;
			end else if (col_sum > {1'b0, cfg.image_width}) begin
				status = ST_LEAVES;
			end else if ({8'd0, need} > room) begin
				status = trunc_code;
			end else begin
				bpos_d  = bpos_q + 16'd1;
				pleft_d = need;
				prun_d  = len;
			end
			err_d = status;
		end else begin
			// Payload byte; advance the column once the run is consumed
			bpos_d  = bpos_q + 16'd1;
			pleft_d = pleft_dec;
			if (pleft_dec == 8'd0) begin
				col_d  = col_adv;
				prun_d = 7'd0;
				if (col_adv >= cfg.image_width) begin
					inl_d   = 1'b0;
					lines_d = lines_q + 8'd1;
					if (({1'b0, lines_q} + 9'd1) >= {1'b0, cfg.image_height}) begin
						status = ST_IMAGE;
					end else begin
						status = ST_LINE;
					end
				end
			end
		end
	end

	assign res.status      = status;
	assign res.line_number = lines_q;
	assign res.column      = col_d;

	// Commit on each processed beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_q   <= ST_MORE;
			col_q   <= '0;
			bpos_q  <= '0;
			pleft_q <= '0;
			prun_q  <= '0;
			lines_q <= '0;
			inl_q   <= 1'b0;
		end else if (fire) begin
			err_q   <= err_d;
			col_q   <= col_d;
			bpos_q  <= bpos_d;
			pleft_q <= pleft_d;
			prun_q  <= prun_d;
			lines_q <= lines_d;
			inl_q   <= inl_d;
		end
	end

endmodule

/* hw/rtl/xbin_rle_line_validator_unit.sv */
// Run-length coded text-mode image checker, one line at a time. Send a line-start
// beat carrying the line's byte offset, then the line's compressed bytes, one per
// beat; every input beat yields exactly one result beat (status, line number,
// column). The block takes one beat per clock cycle while the result side is not
// stalling. Each result passes through the input register, then the result register;
// the run state (byte position, payload count, column) is updated as each beat is
// processed, so a new beat can follow at once while results are taken.
// The first error is sticky until reset. Write image_width (0x0), image_height
// (0x4) and data_len (0x8) over the APB port only while no beat is in flight;
// reset values are 80, 25 and 0. AREA_MAX bounds width times height.
module xbin_rle_line_validator_unit import xbrv_pkg::*; #(
	parameter int unsigned AREA_MAX = 32768
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	xbrv_req_if.sink          req,
	xbrv_rsp_if.source        rsp
);

	cfg_t cfg;
	req_t item_s1;
	logic valid_s1;
	res_t res;
	res_t res_s2;
	logic valid_s2;
	logic advance;

	xbrv_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Process the held beat whenever the result register is free or draining
	assign advance   = valid_s1 && (!valid_s2 || rsp.ready);
	assign req.ready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.valid && req.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			item_s1.req_type    <= req.req_type;
			item_s1.line_offset <= req.line_offset;
			item_s1.data_byte   <= req.data_byte;
		end
	end

	xbrv_core #(
		.AREA_MAX (AREA_MAX)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (advance),
		.cfg    (cfg),
		.item   (item_s1),
		.res    (res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (rsp.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign rsp.valid       = valid_s2;
	assign rsp.status      = res_s2.status;
	assign rsp.line_number = res_s2.line_number;
	assign rsp.column      = res_s2.column;

endmodule

/* hw/rtl/xbrv_chk.sv */
module xbrv_chk import xbrv_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       pready,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic [3:0] rsp_status,
	input logic [7:0] rsp_line_number,
	input logic [7:0] rsp_column
);

	logic       err_seen_q;
	logic [3:0] err_code_q;
	logic       rsp_beat;
	logic       rsp_is_err;

	assign rsp_beat   = rsp_valid && rsp_ready;
	assign rsp_is_err = (rsp_status != ST_MORE) && (rsp_status != ST_LINE)
		&& (rsp_status != ST_IMAGE);

	// Remember the first error delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_seen_q <= 1'b0;
			err_code_q <= ST_MORE;
		end else if (rsp_beat && rsp_is_err && !err_seen_q) begin
			err_seen_q <= 1'b1;
			err_code_q <= rsp_status;
		end
	end

	// Once an error has gone out, every later result repeats it
	a_sticky_error: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && err_seen_q) |-> (rsp_status == err_code_q))
		else $error("error status not sticky");

	// No status code beyond the defined set
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_status <= ST_UNEXPECTED))
		else $error("status out of range");

	// The configuration port never inserts wait states
	a_pready_high: assert property (@(posedge clk) disable iff (!arst_n)
		pready)
		else $error("pready dropped");

	// A stalled result holds its payload
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_status)
			&& $stable(rsp_line_number) && $stable(rsp_column)))
		else $error("stalled result changed");

endmodule

bind xbin_rle_line_validator_unit xbrv_chk u_xbrv_chk (
	.clk             (clk),
	.arst_n          (arst_n),
	.pready          (pready),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_status      (rsp.status),
	.rsp_line_number (rsp.line_number),
	.rsp_column      (rsp.column)
);
